// File: rtl/spbm_pkg.sv
// spbm_pkg: shared types and constants for the striped partition block mapper.
// Used by spbm_regs and striped_partition_block_mapper_unit; no dependencies.
`timescale 1ns / 1ps

package spbm_pkg;

  localparam int LBLOCK_W = 19;   // logical block number width
  localparam int LOCAL_W  = 16;   // local block number width
  localparam int PIDX_W   = 3;    // partition index width
  localparam int COUNT_W  = 4;    // part_count register width
  localparam int DATA_W   = 64;   // configuration write data width
  localparam int REG_W    = 2;    // configuration register index width
  localparam int FIELD_W  = 16;   // size field pitch inside a sizes word

  localparam logic [REG_W-1:0] REG_PART_COUNT  = 2'd0;
  localparam logic [REG_W-1:0] REG_INTERLEAVED = 2'd1;
  localparam logic [REG_W-1:0] REG_SIZES_LOW   = 2'd2;
  localparam logic [REG_W-1:0] REG_SIZES_HIGH  = 2'd3;

  // Mapping mode derived from the configuration registers.
  typedef struct packed {
    logic               stripe;  // interleaved lookup in force
    logic [1:0]         shift;   // log2 of the stripe width
    logic [COUNT_W-1:0] count;   // effective partition count
    logic               busy;    // partition end table being refreshed
  } mode_t;

endpackage

// File: rtl/spbm_regs.sv
// spbm_regs: configuration registers and the registered table of partition ends.
// Depends on spbm_pkg.
`timescale 1ns / 1ps

module spbm_regs #(
  parameter int MAX_PARTS  = 8,
  parameter int BLOCK_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [spbm_pkg::REG_W-1:0]                  cfg_index,
  input  logic [spbm_pkg::DATA_W-1:0]                 cfg_data,
  output spbm_pkg::mode_t                             mode,
  output logic [MAX_PARTS-1:0][spbm_pkg::LBLOCK_W-1:0] ends
);

  logic [spbm_pkg::COUNT_W-1:0]                 part_count;
  logic                                         interleaved;
  logic [MAX_PARTS-1:0][BLOCK_BITS-1:0]         sizes;
  logic [MAX_PARTS-1:0][spbm_pkg::LBLOCK_W-1:0] ends_next;
  logic                                         busy;
  logic [spbm_pkg::COUNT_W-1:0]                 count;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_count  <= spbm_pkg::COUNT_W'(1);
      interleaved <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spbm_pkg::REG_PART_COUNT:  part_count  <= cfg_data[spbm_pkg::COUNT_W-1:0];
        spbm_pkg::REG_INTERLEAVED: interleaved <= cfg_data[0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < MAX_PARTS; g++) begin : g_size
    localparam logic [spbm_pkg::REG_W-1:0] WORD =
      (g < 4) ? spbm_pkg::REG_SIZES_LOW : spbm_pkg::REG_SIZES_HIGH;
    localparam int LSB = (g % 4) * spbm_pkg::FIELD_W;
    always_ff @(posedge clk) begin
      if (rst) begin
        sizes[g] <= '0;
      end else if (cfg_we && cfg_index == WORD) begin
        sizes[g] <= cfg_data[LSB +: BLOCK_BITS];
      end
    end
  end

  // running sum of sizes: end of partition i is first block past it
  always_comb begin
    ends_next[0] = spbm_pkg::LBLOCK_W'(sizes[0]);
    for (int i = 1; i < MAX_PARTS; i++) begin
      ends_next[i] = ends_next[i-1] + spbm_pkg::LBLOCK_W'(sizes[i]);
    end
  end

  always_ff @(posedge clk) begin
    ends <= ends_next;
  end

  // end table is registered behind the size registers; busy holds requests after any config write
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= cfg_we;
    end
  end

  assign count = (part_count > spbm_pkg::COUNT_W'(MAX_PARTS)) ?
                 spbm_pkg::COUNT_W'(MAX_PARTS) : part_count;

  always_comb begin
    mode.count  = count;
    mode.busy   = busy;
    mode.stripe = interleaved && (count >= spbm_pkg::COUNT_W'(2));
    if (count >= spbm_pkg::COUNT_W'(8)) begin
      mode.shift = 2'd3;
    end else if (count >= spbm_pkg::COUNT_W'(4)) begin
      mode.shift = 2'd2;
    end else begin
      mode.shift = 2'd1;
    end
  end

endmodule

// File: rtl/striped_partition_block_mapper_unit.sv
// striped_partition_block_mapper_unit: top level of the partition block mapper.
// Depends on spbm_pkg and spbm_regs.
//
//   channel | handshake              | payload
//   req     | req_valid / req_stall  | logical_block
//   res     | res_valid / res_stall  | found, part_index, local_block
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while req_stall is low; a result passes through the
// request register, then the lookup into the result register.
// A configuration write holds req_stall high for one cycle while the
// partition end table is rebuilt; reset does the same for its first cycle.
// res_stall freezes the result register; the request register keeps one more.
`timescale 1ns / 1ps

module striped_partition_block_mapper_unit #(
  parameter int MAX_PARTS  = 8,
  parameter int BLOCK_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [spbm_pkg::LBLOCK_W-1:0]      logical_block,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               found,
  output logic [spbm_pkg::PIDX_W-1:0]        part_index,
  output logic [spbm_pkg::LOCAL_W-1:0]       local_block,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spbm_pkg::REG_W-1:0]         cfg_index,
  input  logic [spbm_pkg::DATA_W-1:0]        cfg_data
);

  localparam logic [spbm_pkg::LOCAL_W-1:0] BLOCK_MASK =
    spbm_pkg::LOCAL_W'((17'd1 << BLOCK_BITS) - 17'd1);

  spbm_pkg::mode_t                              mode;
  logic [MAX_PARTS-1:0][spbm_pkg::LBLOCK_W-1:0] ends;
  logic [MAX_PARTS-1:0][spbm_pkg::LBLOCK_W-1:0] starts;
  logic [MAX_PARTS-1:0]                         hit;

  logic                          s1_valid;
  logic [spbm_pkg::LBLOCK_W-1:0] s1_block;
  logic                          s2_adv;
  logic                          s1_free;

  logic                          found_next;
  logic [spbm_pkg::PIDX_W-1:0]   part_index_next;
  logic [spbm_pkg::LOCAL_W-1:0]  local_block_next;
  logic [spbm_pkg::LBLOCK_W-1:0] start_sel;
  logic [spbm_pkg::PIDX_W-1:0]   idx_sel;
  logic                          any_hit;
  logic [spbm_pkg::PIDX_W-1:0]   stripe_mask;

  assign cfg_ready = 1'b1;

  spbm_regs #(
    .MAX_PARTS  (MAX_PARTS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .ends      (ends)
  );

  assign s2_adv    = !res_valid || !res_stall;
  assign s1_free   = !s1_valid || s2_adv;
  assign req_stall = !s1_free || mode.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= req_valid && !mode.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_block <= logical_block;
    end
  end

  // concatenated lookup: first partition whose end lies past the block
  for (genvar g = 0; g < MAX_PARTS; g++) begin : g_part
    if (g == 0) begin : g_first
      assign starts[g] = '0;
    end else begin : g_rest
      assign starts[g] = ends[g-1];
    end
    assign hit[g] = (spbm_pkg::COUNT_W'(g) < mode.count) && (s1_block < ends[g]);
  end

  always_comb begin
    any_hit   = 1'b0;
    idx_sel   = '0;
    start_sel = '0;
    for (int i = MAX_PARTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit   = 1'b1;
        idx_sel   = spbm_pkg::PIDX_W'(i);
        start_sel = starts[i];
      end
    end
  end

  assign stripe_mask = spbm_pkg::PIDX_W'((4'd1 << mode.shift) - 4'd1);

  always_comb begin
    if (mode.stripe) begin
      found_next       = 1'b1;
      part_index_next  = s1_block[spbm_pkg::PIDX_W-1:0] & stripe_mask;
      local_block_next = spbm_pkg::LOCAL_W'(s1_block >> mode.shift) & BLOCK_MASK;
    end else if (any_hit) begin
      found_next       = 1'b1;
      part_index_next  = idx_sel;
      local_block_next = spbm_pkg::LOCAL_W'(s1_block - start_sel);
    end else begin
      found_next       = 1'b0;
      part_index_next  = '0;
      local_block_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      found       <= found_next;
      part_index  <= part_index_next;
      local_block <= local_block_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !found) |-> (part_index == '0 && local_block == '0))
    else $error("miss result carries non-zero fields");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_adv) |=> res_valid)
    else $error("request lost between stages");

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    mode.busy |-> req_stall)
    else $error("request taken while end table refreshes");

  a_concat_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && found && !mode.stripe) |->
      (spbm_pkg::COUNT_W'(part_index) < mode.count))
    else $error("partition index beyond partition count");
`endif

endmodule

// File: verif/testbench.sv
// testbench: self-checking regression for striped_partition_block_mapper_unit.
// Depends on spbm_pkg and the mapper RTL. Each result is checked against an in-bench
// mapping model, using directed cases, random configurations and back-pressure.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_PARTS  = 8;
  localparam int BLOCK_BITS = 16;
  localparam int LB_MAX     = (1 << spbm_pkg::LBLOCK_W) - 1;
  localparam int HOLD_LEN   = 40;
  localparam int DRAIN      = 4;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES     = 13;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic                         found;
    logic [spbm_pkg::PIDX_W-1:0]  part_index;
    logic [spbm_pkg::LOCAL_W-1:0] local_block;
  } map_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  logic [spbm_pkg::LBLOCK_W-1:0] logical_block = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  logic                          found;
  logic [spbm_pkg::PIDX_W-1:0]   part_index;
  logic [spbm_pkg::LOCAL_W-1:0]  local_block;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [spbm_pkg::REG_W-1:0]    cfg_index = '0;
  logic [spbm_pkg::DATA_W-1:0]   cfg_data = '0;

  // register shadow
  logic [spbm_pkg::COUNT_W-1:0]  count_sh;
  logic                          stripe_sh;
  logic [spbm_pkg::DATA_W-1:0]   sizes_lo_sh;
  logic [spbm_pkg::DATA_W-1:0]   sizes_hi_sh;

  map_result_t         pending_maps[$];
  int unsigned         errors = 0;
  int unsigned         blocks_sent = 0;
  int unsigned         maps_checked = 0;
  int unsigned         reg_writes = 0;
  int unsigned         idle_cycles = 0;
  bit                  sender_gaps = 1'b0;
  bit                  rx_gaps = 1'b0;
  logic                hold_req = 1'b0;
  logic                hold_ack = 1'b0;
  int                  stall_left = 0;

  striped_partition_block_mapper_unit #(
    .MAX_PARTS (MAX_PARTS),
    .BLOCK_BITS(BLOCK_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .logical_block(logical_block),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .found        (found),
    .part_index   (part_index),
    .local_block  (local_block),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [spbm_pkg::LOCAL_W-1:0] part_size(input int idx);
    logic [spbm_pkg::DATA_W-1:0] word;
    word = (idx < 4) ? sizes_lo_sh : sizes_hi_sh;
    return spbm_pkg::LOCAL_W'((word >> ((idx % 4) * spbm_pkg::FIELD_W)) &
                              ((64'd1 << BLOCK_BITS) - 64'd1));
  endfunction

  function automatic int part_total(input int upto);
    int i;
    int sum;
    sum = 0;
    for (i = 0; i < upto; i++) sum += part_size(i);
    return sum;
  endfunction

  function automatic int live_parts();
    return (count_sh > MAX_PARTS) ? MAX_PARTS : count_sh;
  endfunction

  function automatic map_result_t map_block(input logic [spbm_pkg::LBLOCK_W-1:0] lb);
    map_result_t r;
    int n;
    int k;
    int i;
    logic [spbm_pkg::LBLOCK_W-1:0] rem;
    logic [spbm_pkg::LOCAL_W-1:0] sz;
    r = '0;
    n = live_parts();
    if (stripe_sh && n >= 2) begin
      k = (n >= 8) ? 3 : (n >= 4) ? 2 : 1;
      r.found = 1'b1;
      r.part_index = spbm_pkg::PIDX_W'(lb & ((1 << k) - 1));
      r.local_block = spbm_pkg::LOCAL_W'((lb >> k) & ((1 << BLOCK_BITS) - 1));
    end else begin
      rem = lb;
      for (i = 0; i < n; i++) begin
        sz = part_size(i);
        if (!r.found) begin
          if ({3'b0, sz} > rem) begin
            r.found = 1'b1;
            r.part_index = spbm_pkg::PIDX_W'(i);
            r.local_block = spbm_pkg::LOCAL_W'(rem);
          end else begin
            rem = rem - {3'b0, sz};
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_block(input logic [spbm_pkg::LBLOCK_W-1:0] lb);
    req_valid <= 1'b1;
    logical_block <= lb;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_maps.push_back(map_block(lb));
    blocks_sent++;
    if (sender_gaps && $urandom_range(0, 99) < 25) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [spbm_pkg::REG_W-1:0] idx,
                           input logic [spbm_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      spbm_pkg::REG_PART_COUNT:  count_sh = data[spbm_pkg::COUNT_W-1:0];
      spbm_pkg::REG_INTERLEAVED: stripe_sh = data[0];
      spbm_pkg::REG_SIZES_LOW:   sizes_lo_sh = data;
      spbm_pkg::REG_SIZES_HIGH:  sizes_hi_sh = data;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are junk on purpose; only the low field should matter
  task automatic configure(input logic [spbm_pkg::COUNT_W-1:0] cnt, input logic stripe,
                           input logic [spbm_pkg::DATA_W-1:0] lo,
                           input logic [spbm_pkg::DATA_W-1:0] hi);
    logic [spbm_pkg::DATA_W-1:0] junk;
    wait_idle();
    junk = {$urandom, $urandom};
    write_reg(spbm_pkg::REG_PART_COUNT, {junk[spbm_pkg::DATA_W-1:spbm_pkg::COUNT_W], cnt});
    junk = {$urandom, $urandom};
    write_reg(spbm_pkg::REG_INTERLEAVED, {junk[spbm_pkg::DATA_W-1:1], stripe});
    write_reg(spbm_pkg::REG_SIZES_LOW, lo);
    write_reg(spbm_pkg::REG_SIZES_HIGH, hi);
  endtask

  // result check and receiver stall
  always @(posedge clk) begin
    map_result_t exp_map;
    if (res_valid && !res_stall) begin
      if (pending_maps.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_map = pending_maps.pop_front();
        maps_checked++;
        if (found !== exp_map.found) begin
          $error("found: expected %0d, got %0d", exp_map.found, found);
          errors++;
        end
        if (part_index !== exp_map.part_index) begin
          $error("part_index: expected %0d, got %0d", exp_map.part_index, part_index);
          errors++;
        end
        if (local_block !== exp_map.local_block) begin
          $error("local_block: expected %0d, got %0d", exp_map.local_block, local_block);
          errors++;
        end
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      stall_left <= HOLD_LEN - 1;
      res_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall <= 1'b1;
    end else if (rx_gaps && $urandom_range(0, 99) < 25) begin
      stall_left <= $urandom_range(0, 4);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_block('0);
    send_block(spbm_pkg::LBLOCK_W'(LB_MAX));
  endtask

  task automatic test_concat_boundaries();
    int total;
    // sizes 10, 0, 100, 0 | 65535, 1, 0, 5
    configure(4'd8, 1'b0, {16'd0, 16'd100, 16'd0, 16'd10},
              {16'd5, 16'd0, 16'd1, 16'hFFFF});
    total = part_total(8);
    send_block(spbm_pkg::LBLOCK_W'(0));
    send_block(spbm_pkg::LBLOCK_W'(9));
    send_block(spbm_pkg::LBLOCK_W'(10));
    send_block(spbm_pkg::LBLOCK_W'(109));
    send_block(spbm_pkg::LBLOCK_W'(110));
    send_block(spbm_pkg::LBLOCK_W'(110 + 65534));
    send_block(spbm_pkg::LBLOCK_W'(110 + 65535));
    send_block(spbm_pkg::LBLOCK_W'(total - 1));
    send_block(spbm_pkg::LBLOCK_W'(total));
    send_block(spbm_pkg::LBLOCK_W'(LB_MAX));
  endtask

  task automatic test_empty_and_saturated();
    configure(4'd0, 1'b0, '1, '1);
    send_block(spbm_pkg::LBLOCK_W'(0));
    configure(4'd0, 1'b1, '1, '1);
    send_block(spbm_pkg::LBLOCK_W'(5));
    // count above eight is clamped; full sizes leave the top few blocks unmapped
    configure(4'd15, 1'b0, '1, '1);
    send_block(spbm_pkg::LBLOCK_W'(8 * 65535 - 1));
    send_block(spbm_pkg::LBLOCK_W'(LB_MAX));
  endtask

  task automatic test_striping();
    configure(4'd1, 1'b1, {48'd0, 16'd20}, '0);
    send_block(spbm_pkg::LBLOCK_W'(19));
    send_block(spbm_pkg::LBLOCK_W'(20));
    configure(4'd3, 1'b1, '0, '0);
    send_block(spbm_pkg::LBLOCK_W'(LB_MAX));
    configure(4'd2, 1'b1, '0, '0);
    send_block(spbm_pkg::LBLOCK_W'(LB_MAX));
    configure(4'd4, 1'b1, '0, '0);
    send_block(spbm_pkg::LBLOCK_W'(6));
    configure(4'd8, 1'b1, '0, '0);
    send_block(spbm_pkg::LBLOCK_W'(LB_MAX));
  endtask

  task automatic test_backpressure();
    int i;
    configure(4'd8, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
    sender_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_req <= ~hold_req;
    for (i = 0; i < 24; i++) send_block(spbm_pkg::LBLOCK_W'($urandom));
    wait_idle();
  endtask

  task automatic test_random_phases();
    int ph;
    int i;
    int j;
    int n;
    int total;
    int pick;
    int lb;
    int sel;
    logic [spbm_pkg::COUNT_W-1:0] cnt;
    logic [spbm_pkg::FIELD_W-1:0] sz;
    logic [spbm_pkg::DATA_W-1:0] words[2];
    for (ph = 0; ph < PHASES; ph++) begin
      sender_gaps = (ph < PHASES - 2);
      rx_gaps = (ph < PHASES - 2);
      sel = $urandom_range(0, 9);
      if (sel < 2) cnt = spbm_pkg::COUNT_W'($urandom);
      else cnt = spbm_pkg::COUNT_W'(1 << $urandom_range(0, 3));
      for (j = 0; j < 8; j++) begin
        case ($urandom_range(0, 5))
          0: sz = '0;
          1: sz = '1;
          2: sz = spbm_pkg::FIELD_W'($urandom_range(1, 16));
          default: sz = spbm_pkg::FIELD_W'($urandom);
        endcase
        if (ph == 0) sz = '1;
        if (ph == 1) sz = '0;
        words[j / 4][(j % 4) * spbm_pkg::FIELD_W +: spbm_pkg::FIELD_W] = sz;
      end
      configure(cnt, (ph > 1) ? logic'($urandom_range(0, 1)) : 1'b0, words[0], words[1]);
      n = live_parts();
      total = part_total(n);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 9);
        if (stripe_sh || n == 0 || pick < 2) begin
          lb = $urandom_range(0, LB_MAX);
        end else if (pick < 5) begin
          lb = $urandom_range(0, total + 8);
        end else begin
          lb = part_total($urandom_range(1, n)) + $urandom_range(0, 2) - 1;
        end
        if (lb < 0) lb = 0;
        if (lb > LB_MAX) lb = LB_MAX;
        send_block(spbm_pkg::LBLOCK_W'(lb));
      end
    end
  endtask

  initial begin
    count_sh = spbm_pkg::COUNT_W'(1);
    stripe_sh = 1'b0;
    sizes_lo_sh = '0;
    sizes_hi_sh = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_concat_boundaries();
    test_empty_and_saturated();
    test_striping();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_maps.size() != 0) begin
      $error("%0d results never arrived", pending_maps.size());
      errors++;
    end
    $display("Mapped %0d blocks (%0d results checked) over %0d register writes,",
             blocks_sent, maps_checked, reg_writes);
    $display("covering concatenated, striped, empty and clamped layouts with stalls.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
